/* hw/rtl/button_press_classifier_defines.svh */
// Assertion macros used by the button press classifier checker.
`ifndef BUTTON_PRESS_CLASSIFIER_DEFINES_SVH
`define BUTTON_PRESS_CLASSIFIER_DEFINES_SVH

// Clocked assertion, masked while reset is asserted.
`define BPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same-cycle implication.
`define BPC_ASSERT_IMP(lbl, ante, cons, msg) \
  `BPC_ASSERT(lbl, (ante) |-> (cons), msg)

// Next-cycle implication.
`define BPC_ASSERT_NXT(lbl, ante, cons, msg) \
  `BPC_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

/* hw/rtl/bpc_pkg.sv */
// Types, constants and codes shared by the button press classifier.
`default_nettype none

package bpc_pkg;

  localparam int unsigned TickWidthDefault = 16;

  localparam int unsigned CfgIdxWidth  = 2;
  localparam int unsigned CfgDataWidth = 32;
  localparam int unsigned InDataWidth  = 8;
  localparam int unsigned OutDataWidth = 8;

  localparam int unsigned DebounceReset  = 20;
  localparam int unsigned LongPressReset = 500;
  localparam int unsigned RepeatReset    = 100;

  // Result word layout, lowest bit first
  localparam int unsigned OutShortBit  = 0;
  localparam int unsigned OutLongBit   = 1;
  localparam int unsigned OutRepeatBit = 2;
  localparam int unsigned OutModeLsb   = 3;
  localparam int unsigned OutModeMsb   = 4;

  typedef enum logic [1:0] {
    MODE_IDLE     = 2'd0,
    MODE_DEBOUNCE = 2'd1,
    MODE_PRESSED  = 2'd2,
    MODE_REPEAT   = 2'd3
  } mode_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_DEBOUNCE   = 2'd0,
    REG_LONG_PRESS = 2'd1,
    REG_REPEAT     = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic short_press;
    logic long_press;
    logic repeat_pulse;
  } pulse_t;

endpackage

`default_nettype wire

/* hw/rtl/bpc_cfg_regs.sv */
// Timing threshold registers written through the configuration channel.
`default_nettype none

module bpc_cfg_regs #(
  parameter int unsigned TICK_WIDTH = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_valid_i,
  input  wire logic [bpc_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  wire logic [bpc_pkg::CfgDataWidth-1:0] cfg_data_i,
  output logic      [TICK_WIDTH-1:0]            debounce_o,
  output logic      [TICK_WIDTH-1:0]            long_press_o,
  output logic      [TICK_WIDTH-1:0]            repeat_o
);
  import bpc_pkg::*;

  logic [TICK_WIDTH-1:0] debounce_q,   debounce_d;
  logic [TICK_WIDTH-1:0] long_press_q, long_press_d;
  logic [TICK_WIDTH-1:0] repeat_q,     repeat_d;
  logic [TICK_WIDTH-1:0] wr_value;

  // only the low TICK_WIDTH bits are kept
  assign wr_value = cfg_data_i[TICK_WIDTH-1:0];

  always_comb begin
    debounce_d   = debounce_q;
    long_press_d = long_press_q;
    repeat_d     = repeat_q;
    if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_DEBOUNCE:   debounce_d   = wr_value;
        REG_LONG_PRESS: long_press_d = wr_value;
        REG_REPEAT:     repeat_d     = wr_value;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= TICK_WIDTH'(DebounceReset);
      long_press_q <= TICK_WIDTH'(LongPressReset);
      repeat_q     <= TICK_WIDTH'(RepeatReset);
    end else begin
      debounce_q   <= debounce_d;
      long_press_q <= long_press_d;
      repeat_q     <= repeat_d;
    end
  end

  assign debounce_o   = debounce_q;
  assign long_press_o = long_press_q;
  assign repeat_o     = repeat_q;

endmodule

`default_nettype wire

/* hw/rtl/bpc_fsm.sv */
// Mode state machine and saturating elapsed-tick counter.
`default_nettype none

module bpc_fsm #(
  parameter int unsigned TICK_WIDTH = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  step_i,
  input  wire logic                  pin_i,
  input  wire logic [TICK_WIDTH-1:0] debounce_i,
  input  wire logic [TICK_WIDTH-1:0] long_press_i,
  input  wire logic [TICK_WIDTH-1:0] repeat_i,
  output bpc_pkg::pulse_t            pulse_o,
  output bpc_pkg::mode_e             mode_o
);
  import bpc_pkg::*;

  localparam int unsigned CntWidth = TICK_WIDTH + 1;

  mode_e                mode_q, mode_d;
  logic [CntWidth-1:0]  cnt_q, cnt_d, cnt_inc;
  logic                 debounce_done, long_done, repeat_done;

  // counter sticks at all ones, which is above any threshold
  assign cnt_inc = (&cnt_q) ? cnt_q : CntWidth'(cnt_q + 1'b1);

  assign debounce_done = cnt_inc > {1'b0, debounce_i};
  assign long_done     = cnt_inc > {1'b0, long_press_i};
  assign repeat_done   = cnt_inc > {1'b0, repeat_i};

  // next state and counter
  always_comb begin
    mode_d = mode_q;
    cnt_d  = cnt_inc;
    unique case (mode_q)
      MODE_IDLE: begin
        if (pin_i) begin
          mode_d = MODE_DEBOUNCE;
          cnt_d  = '0;
        end
      end
      MODE_DEBOUNCE: begin
        if (debounce_done) begin
          if (pin_i) begin
            mode_d = MODE_PRESSED;
            cnt_d  = '0;
          end else begin
            mode_d = MODE_IDLE;
          end
        end
      end
      MODE_PRESSED: begin
        if (!pin_i) begin
          mode_d = MODE_IDLE;
        end else if (long_done) begin
          mode_d = MODE_REPEAT;
          cnt_d  = '0;
        end
      end
      MODE_REPEAT: begin
        if (!pin_i) begin
          mode_d = MODE_IDLE;
        end else if (repeat_done) begin
          cnt_d = '0;
        end
      end
      default: begin
        mode_d = MODE_IDLE;
        cnt_d  = '0;
      end
    endcase
  end

  // pulse outputs
  always_comb begin
    pulse_o = '0;
    unique case (mode_q)
      MODE_IDLE, MODE_DEBOUNCE: ;
      MODE_PRESSED: begin
        pulse_o.short_press = !pin_i;
        pulse_o.long_press  = pin_i && long_done;
      end
      MODE_REPEAT:  pulse_o.repeat_pulse = pin_i && repeat_done;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      cnt_q  <= '0;
    end else if (step_i) begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
    end
  end

  assign mode_o = mode_d;

endmodule

`default_nettype wire

/* hw/rtl/button_press_classifier.sv */
// Button press classifier top level: input register, mode logic, result register.
//
//  channel   | direction | tdata bits (low first)                        | handshake
//  ----------+-----------+-----------------------------------------------+-----------------
//  s_axis    | in        | pin_level[0], ignored[7:1]                    | tvalid/tready
//  m_axis    | out       | short[0] long[1] repeat[2] mode_now[4:3] 0s   | tvalid/tready
//  cfg       | in        | cfg_index_i selects register, cfg_data_i value| valid/ready
//
// One tick per clock while the result is not stalled: a tick is registered in the
// input register, then the mode logic writes its result register.
// Reset returns mode to idle, clears the counter and loads 20 / 500 / 100.
// A stalled result holds the input register, which then drops s_axis_tready_o.
`default_nettype none

module button_press_classifier #(
  parameter int unsigned TICK_WIDTH = bpc_pkg::TickWidthDefault
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  input  wire logic [bpc_pkg::InDataWidth-1:0]  s_axis_tdata_i,  // pin_level[0]
  output logic                                  m_axis_tvalid_o,
  input  wire logic                             m_axis_tready_i,
  // short_press_pulse[0], long_press_pulse[1], repeat_pulse[2], mode_now[4:3]
  output logic      [bpc_pkg::OutDataWidth-1:0] m_axis_tdata_o,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [bpc_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  wire logic [bpc_pkg::CfgDataWidth-1:0] cfg_data_i
);
  import bpc_pkg::*;

  logic                    in_valid_q, in_valid_d;
  logic                    pin_q;
  logic                    out_valid_q, out_valid_d;
  logic [OutDataWidth-1:0] out_data_q, out_data_d;
  logic                    s_xfer, advance;
  logic [TICK_WIDTH-1:0]   debounce_thr, long_press_thr, repeat_thr;
  pulse_t                  pulse;
  mode_e                   mode_next;

  assign cfg_ready_o = 1'b1;

  bpc_cfg_regs #(
    .TICK_WIDTH (TICK_WIDTH)
  ) u_cfg_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .debounce_o   (debounce_thr),
    .long_press_o (long_press_thr),
    .repeat_o     (repeat_thr)
  );

  // tick moves on when the result register is free or draining this cycle
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign s_xfer          = s_axis_tvalid_i && s_axis_tready_o;

  bpc_fsm #(
    .TICK_WIDTH (TICK_WIDTH)
  ) u_fsm (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .pin_i        (pin_q),
    .debounce_i   (debounce_thr),
    .long_press_i (long_press_thr),
    .repeat_i     (repeat_thr),
    .pulse_o      (pulse),
    .mode_o       (mode_next)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_xfer) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_data_d                         = '0;
    out_data_d[OutShortBit]            = pulse.short_press;
    out_data_d[OutLongBit]             = pulse.long_press;
    out_data_d[OutRepeatBit]           = pulse.repeat_pulse;
    out_data_d[OutModeMsb:OutModeLsb]  = mode_next;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      pin_q <= s_axis_tdata_i[0];
    end
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

`default_nettype wire

/* hw/rtl/bpc_checker.sv */
// Port-level checks for the button press classifier, bound to the top level.
`default_nettype none

`include "button_press_classifier_defines.svh"

module bpc_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             slv_tvalid_i,
  input wire logic                             slv_tready_i,
  input wire logic                             mst_tvalid_i,
  input wire logic                             mst_tready_i,
  input wire logic [bpc_pkg::OutDataWidth-1:0] mst_tdata_i
);
  import bpc_pkg::*;

  logic slv_xfer;
  logic [1:0] mode_seen;

  assign slv_xfer  = slv_tvalid_i && slv_tready_i;
  assign mode_seen = mst_tdata_i[OutModeMsb:OutModeLsb];

  `BPC_ASSERT_NXT(a_out_hold, mst_tvalid_i && !mst_tready_i, mst_tvalid_i && $stable(mst_tdata_i), "result changed while stalled")

  `BPC_ASSERT_IMP(a_one_pulse, mst_tvalid_i, $countones(mst_tdata_i[OutRepeatBit:OutShortBit]) <= 1, "more than one pulse in a result")

  `BPC_ASSERT_IMP(a_pulse_mode, mst_tvalid_i, (!mst_tdata_i[OutShortBit] || mode_seen == MODE_IDLE) && ((!mst_tdata_i[OutLongBit] && !mst_tdata_i[OutRepeatBit]) || mode_seen == MODE_REPEAT), "pulse inconsistent with mode")

  `BPC_ASSERT_IMP(a_latency, slv_xfer && !mst_tvalid_i, ##2 mst_tvalid_i, "result not presented two cycles after transfer")

endmodule

bind button_press_classifier bpc_checker u_bpc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .slv_tvalid_i (s_axis_tvalid_i),
  .slv_tready_i (s_axis_tready_o),
  .mst_tvalid_i (m_axis_tvalid_o),
  .mst_tready_i (m_axis_tready_i),
  .mst_tdata_i  (m_axis_tdata_o)
);

`default_nettype wire

/* verif/tb_button_press_classifier.sv */
// Self-checking testbench for the button press classifier: stream driver, result monitor.
`timescale 1ns / 1ps

module tb_button_press_classifier;
  import bpc_pkg::*;

  localparam int unsigned TickW = TickWidthDefault;
  localparam int unsigned CycleLimit = 200_000;
  localparam logic [CfgIdxWidth-1:0] RegUnused = 2'd3;

  typedef struct packed {
    logic  short_p;
    logic  long_p;
    logic  rep_p;
    mode_e mode_now;
  } press_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                    s_valid = 1'b0;
  logic [InDataWidth-1:0]  s_data = '0;
  logic                    s_axis_tready_o;
  logic                    m_axis_tvalid_o;
  logic                    m_ready = 1'b0;
  logic [OutDataWidth-1:0] m_axis_tdata_o;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready_o;
  logic [CfgIdxWidth-1:0]  cfg_index = '0;
  logic [CfgDataWidth-1:0] cfg_data = '0;

  button_press_classifier u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_data),         // pin_level[0]
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_axis_tdata_o), // short[0] long[1] repeat[2] mode_now[4:3]
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Mirror of the block's registers and state
  logic [TickW-1:0] debounce_lim = TickW'(DebounceReset);
  logic [TickW-1:0] long_lim     = TickW'(LongPressReset);
  logic [TickW-1:0] repeat_lim   = TickW'(RepeatReset);
  mode_e            cur_mode     = MODE_IDLE;
  logic [TickW:0]   tick_count   = '0;

  logic [InDataWidth-1:0] pin_queue[$];
  press_result_t          results_due[$];

  bit          idle_on = 1'b1;
  bit          tick_taken = 1'b0;
  int unsigned src_gap = 0;
  int unsigned sink_gap = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  function automatic press_result_t classify_tick(input logic pin);
    press_result_t r;
    logic [TickW:0] e;
    r = '0;
    e = (tick_count == '1) ? tick_count : tick_count + 1'b1;
    case (cur_mode)
      MODE_IDLE: begin
        if (pin) begin
          cur_mode = MODE_DEBOUNCE;
          e = '0;
        end
      end
      MODE_DEBOUNCE: begin
        if (e > debounce_lim) begin
          if (pin) begin
            cur_mode = MODE_PRESSED;
            e = '0;
          end else begin
            cur_mode = MODE_IDLE;
          end
        end
      end
      MODE_PRESSED: begin
        if (!pin) begin
          r.short_p = 1'b1;
          cur_mode = MODE_IDLE;
        end else if (e > long_lim) begin
          r.long_p = 1'b1;
          cur_mode = MODE_REPEAT;
          e = '0;
        end
      end
      default: begin
        if (!pin) begin
          cur_mode = MODE_IDLE;
        end else if (e > repeat_lim) begin
          r.rep_p = 1'b1;
          e = '0;
        end
      end
    endcase
    tick_count = e;
    r.mode_now = cur_mode;
    return r;
  endfunction

  // Ticks out of the block first, then ticks into it
  always @(posedge clk_i) begin : monitor
    press_result_t exp_r;
    press_result_t act_r;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_ready) begin
        act_r.short_p  = m_axis_tdata_o[OutShortBit];
        act_r.long_p   = m_axis_tdata_o[OutLongBit];
        act_r.rep_p    = m_axis_tdata_o[OutRepeatBit];
        act_r.mode_now = mode_e'(m_axis_tdata_o[OutModeMsb:OutModeLsb]);
        if (results_due.size() == 0) begin
          $display("%0t: result with none expected, actual %b", $time, m_axis_tdata_o);
          error_count++;
        end else begin
          exp_r = results_due.pop_front();
          if (act_r.short_p !== exp_r.short_p || act_r.long_p !== exp_r.long_p ||
              act_r.rep_p !== exp_r.rep_p || act_r.mode_now !== exp_r.mode_now) begin
            $display("%0t: mismatch, expected short %0b long %0b repeat %0b mode %0d,",
                     $time, exp_r.short_p, exp_r.long_p, exp_r.rep_p, exp_r.mode_now);
            $display("%0t:   actual short %0b long %0b repeat %0b mode %0d", $time,
                     act_r.short_p, act_r.long_p, act_r.rep_p, act_r.mode_now);
            error_count++;
          end
        end
      end
      tick_taken = s_valid && s_axis_tready_o;
      if (tick_taken) begin
        results_due.push_back(classify_tick(s_data[0]));
      end
    end
  end

  always @(negedge clk_i) begin : tick_driver
    logic                   nv;
    logic [InDataWidth-1:0] nd;
    nv = s_valid;
    nd = s_data;
    if (rst_ni && (tick_taken || !s_valid)) begin
      nv = 1'b0;
      if (src_gap != 0) begin
        src_gap--;
      end else if (pin_queue.size() != 0) begin
        if (idle_on && $urandom_range(0, 11) == 0) begin
          src_gap = $urandom_range(0, 18);
        end else begin
          nd = pin_queue.pop_front();
          nv = 1'b1;
        end
      end
    end
    s_valid <= nv;
    s_data <= nd;
  end

  always @(negedge clk_i) begin : sink_driver
    logic rdy;
    rdy = 1'b1;
    if (sink_gap != 0) begin
      sink_gap--;
      rdy = 1'b0;
    end else if (idle_on && $urandom_range(0, 11) == 0) begin
      sink_gap = $urandom_range(0, 18);
      rdy = 1'b0;
    end
    m_ready <= rdy;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout", $time);
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic add_level(input logic pin, input int unsigned n);
    repeat (n) pin_queue.push_back({7'($urandom), pin});
  endtask

  // Holds valid across back-to-back writes; cfg_done lowers it
  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx, input logic [TickW-1:0] value);
    logic [CfgDataWidth-1:0] word;
    word = {16'($urandom), value};
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= word;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_DEBOUNCE:   debounce_lim = word[TickW-1:0];
      REG_LONG_PRESS: long_lim = word[TickW-1:0];
      REG_REPEAT:     repeat_lim = word[TickW-1:0];
      default: ;
    endcase
  endtask

  task automatic cfg_done;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain;
    while (pin_queue.size() != 0 || s_valid || results_due.size() != 0) @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [TickW-1:0] pick_limit(input int unsigned hi);
    case ($urandom_range(0, 5))
      0: return '0;
      1: return TickW'(1);
      default: return TickW'($urandom_range(2, hi));
    endcase
  endfunction

  // Mostly clean presses of random length around the thresholds, some bounce and noise
  task automatic fill_presses(input int unsigned n);
    int unsigned span;
    while (pin_queue.size() < n) begin
      if ($urandom_range(0, 9) < 7) begin
        if ($urandom_range(0, 2) == 0) begin
          repeat ($urandom_range(1, 6)) add_level(1'($urandom_range(0, 1)), 1);
        end
        span = int'(debounce_lim) + int'(long_lim) + 3 * int'(repeat_lim) + 6;
        if (span > 200) span = 200;
        add_level(1'b1, $urandom_range(1, span));
        add_level(1'b0, $urandom_range(1, int'(debounce_lim) + 4));
      end else begin
        repeat ($urandom_range(1, 12)) add_level(1'($urandom_range(0, 1)), 1);
      end
    end
    // a phase may end part way through a press
    while (pin_queue.size() > n) void'(pin_queue.pop_back());
  endtask

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values: one long hold into repeat, then a short press
    add_level(1'b0, 3);
    add_level(1'b1, $urandom_range(630, 700));
    add_level(1'b0, 30);
    add_level(1'b1, 40);
    add_level(1'b0, 30);
    drain();

    // All limits zero: every timed condition fires on the first tick
    write_reg(REG_DEBOUNCE, '0);
    write_reg(REG_LONG_PRESS, '0);
    write_reg(REG_REPEAT, '0);
    write_reg(RegUnused, 16'($urandom));
    cfg_done();
    add_level(1'b0, 1);
    add_level(1'b1, 1);
    add_level(1'b0, 1);  // debounce expires with pin low
    add_level(1'b1, 2);
    add_level(1'b0, 1);  // short press
    add_level(1'b1, 5);  // long press then repeats
    add_level(1'b0, 1);  // silent release from repeat
    add_level(1'b1, 2);
    add_level(1'b0, 2);
    add_level(1'b1, 1);
    add_level(1'b0, 1);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      if (ph >= 6) idle_on = 1'b0;
      write_reg(REG_DEBOUNCE, pick_limit(10));
      write_reg(REG_LONG_PRESS, pick_limit(30));
      write_reg(REG_REPEAT, pick_limit(12));
      if ($urandom_range(0, 1) == 0) write_reg(RegUnused, 16'($urandom));
      cfg_done();
      fill_presses(65);
      drain();
    end

    // Widest limits: a hold that never leaves debounce
    write_reg(REG_DEBOUNCE, '1);
    write_reg(REG_LONG_PRESS, '1);
    write_reg(REG_REPEAT, '1);
    cfg_done();
    add_level(1'b0, 5);
    add_level(1'b1, 40);
    add_level(1'b0, 5);
    drain();

    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
